[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk_i, muted while rst_ni is low
`define APU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// concurrent check on clk_i that also holds through reset
`define APU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/apu_pkg.sv]
`default_nettype none

package apu_pkg;

  // vector and index geometry
  localparam int unsigned VectorLengthDef = 16;
  localparam int unsigned IdxW            = 4;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_STEP_RATE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_DECAY  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SECOND_DECAY = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_STABILIZER   = 2'd3;

  // configuration reset values
  localparam logic [23:0] StepRateRst    = 24'd167772;
  localparam logic [23:0] FirstDecayRst  = 24'd15099494;
  localparam logic [23:0] SecondDecayRst = 24'd16760439;
  localparam logic [31:0] StabilizerRst  = 32'd43;

  // fixed point helpers
  localparam logic [24:0] OneQ24  = 25'h1000000;
  localparam int unsigned HalfQ24 = 2 ** 23;

  // divide / square root unit geometry
  localparam int unsigned NumW = 88;
  localparam int unsigned DenW = 49;
  localparam int unsigned RemW = 50;
  localparam int unsigned CntW = 7;
  localparam logic [CntW-1:0] DivMSteps = 7'd56;
  localparam logic [CntW-1:0] DivVSteps = 7'd88;
  localparam logic [CntW-1:0] SqrtSteps = 7'd32;
  localparam logic [CntW-1:0] DivQSteps = 7'd88;

  // multiplier operations, in issue order
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_P1,
    MUL_P2,
    MUL_M1,
    MUL_M2,
    MUL_GSQ,
    MUL_V1,
    MUL_V2,
    MUL_V3,
    MUL_V4,
    MUL_N1,
    MUL_N2
  } mul_op_e;

  // jobs for the divide / square root unit
  typedef enum logic [1:0] {
    DSU_DIV_M,
    DSU_DIV_V,
    DSU_SQRT,
    DSU_DIV_Q
  } dsu_op_e;

  typedef struct packed {
    logic    load;
    mul_op_e mul_op;
    logic    dsu_start;
    dsu_op_e dsu_op;
    logic    out_load;
  } apu_cmd_t;

  typedef struct packed {
    logic idx_zero;
    logic idx_out;
    logic mul_busy;
    logic dsu_done;
  } apu_stat_t;

endpackage

`default_nettype wire

[design/apu_dsu.sv]
`default_nettype none

`include "assert_macros.svh"

module apu_dsu (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         sqrt_i,
  input  logic [apu_pkg::NumW-1:0]     num_i,
  input  logic [apu_pkg::DenW-1:0]     den_i,
  input  logic [apu_pkg::CntW-1:0]     count_i,
  output logic                         done_o,
  output logic [apu_pkg::NumW-1:0]     quo_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic                        mode_q, mode_d;
  logic [apu_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [apu_pkg::RemW-1:0]    rem_q, rem_d;
  logic [apu_pkg::NumW-1:0]    num_q, num_d;
  logic [apu_pkg::NumW-1:0]    quo_q, quo_d;
  logic [apu_pkg::DenW-1:0]    den_q, den_d;
  logic [apu_pkg::RemW-1:0]    rs, trial, diff;
  logic                        ge;

  // one restoring step: one quotient bit or one root bit
  always_comb begin
    if (mode_q) begin
      rs    = {rem_q[apu_pkg::RemW-3:0], num_q[apu_pkg::NumW-1 -: 2]};
      trial = {16'b0, quo_q[31:0], 2'b01};
    end else begin
      rs    = {rem_q[apu_pkg::RemW-2:0], num_q[apu_pkg::NumW-1]};
      trial = {1'b0, den_q};
    end
    ge   = (rs >= trial);
    diff = rs - trial;
  end

  // iteration control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      mode_d = sqrt_i;
      cnt_d  = count_i;
      rem_d  = '0;
      num_d  = num_i;
      quo_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? diff : rs;
      quo_d = {quo_q[apu_pkg::NumW-2:0], ge};
      num_d = mode_q ? {num_q[apu_pkg::NumW-3:0], 2'b00} : {num_q[apu_pkg::NumW-2:0], 1'b0};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mode_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  `APU_ASSERT(a_no_restart, start_i |-> !busy_q, "dsu started while busy")
  `APU_ASSERT(a_cnt_steps, busy_q |=> (cnt_q == $past(cnt_q) - 7'd1), "dsu count skipped")
  `APU_ASSERT_ALWAYS(a_done_pulse, done_q |=> !done_q, "dsu done longer than one cycle")

endmodule

`default_nettype wire

[design/apu_dp.sv]
`default_nettype none

module apu_dp #(
  parameter int unsigned VECTOR_LENGTH = apu_pkg::VectorLengthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [apu_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic [apu_pkg::IdxW-1:0]       element_index_i,
  input  logic signed [31:0]             grad_value_i,
  input  logic signed [31:0]             param_value_i,
  input  apu_pkg::apu_cmd_t              cmd_i,
  output apu_pkg::apu_stat_t             stat_o,
  output logic signed [31:0]             updated_param_o,
  output logic                           saturated_o
);

  localparam int unsigned MaxDepth = 2 ** apu_pkg::IdxW;
  localparam int unsigned Depth    = (VECTOR_LENGTH < MaxDepth) ? VECTOR_LENGTH : MaxDepth;
  localparam int unsigned AddrW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned AccW     = 97;
  localparam logic signed [AccW-1:0] Half = AccW'(apu_pkg::HalfQ24);
  localparam logic signed [35:0] MaxQ = 36'sd2147483647;
  localparam logic signed [35:0] MinQ = -36'sd2147483648;

  // configuration registers
  logic [23:0] rate_q, b1_q, b2_q;
  logic [31:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= apu_pkg::StepRateRst;
      b1_q   <= apu_pkg::FirstDecayRst;
      b2_q   <= apu_pkg::SecondDecayRst;
      eps_q  <= apu_pkg::StabilizerRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        apu_pkg::CFG_STEP_RATE:    rate_q <= cfg_data_i[23:0];
        apu_pkg::CFG_FIRST_DECAY:  b1_q   <= cfg_data_i[23:0];
        apu_pkg::CFG_SECOND_DECAY: b2_q   <= cfg_data_i[23:0];
        apu_pkg::CFG_STABILIZER:   eps_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // moment stores, zero until first written
  logic signed [31:0] m_mem [Depth];
  logic [63:0]        v_mem [Depth];
  logic [Depth-1:0]   vld_q;
  logic signed [31:0] m_rd_q;
  logic [63:0]        v_rd_q;
  logic signed [31:0] m_old;
  logic [63:0]        v_old;

  // item registers
  logic [apu_pkg::IdxW-1:0] idx_q;
  logic signed [31:0]       g_q, p_q;
  logic                     oor_q;
  logic [8:0]               idx_in_ext;
  logic [7:0]               idx_ext;
  logic [AddrW-1:0]         addr_in;
  logic [AddrW-1:0]         addr;

  assign idx_in_ext = {5'b0, element_index_i};
  assign idx_ext    = {4'b0, idx_q};
  assign addr_in    = idx_in_ext[AddrW-1:0];
  assign addr       = idx_ext[AddrW-1:0];

  // take the item and read both moments of its element
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q  <= element_index_i;
      g_q    <= grad_value_i;
      p_q    <= param_value_i;
      oor_q  <= (idx_in_ext >= 9'(VECTOR_LENGTH));
      m_rd_q <= m_mem[addr_in];
      v_rd_q <= v_mem[addr_in];
    end
  end

  assign m_old = vld_q[addr] ? m_rd_q : '0;
  assign v_old = vld_q[addr] ? v_rd_q : '0;

  // decay powers and product pipeline tag
  logic [24:0]      p1_q, p2_q;
  apu_pkg::mul_op_e pop_q;

  // shared multiplier operands
  logic [24:0]        c1, c2;
  logic [31:0]        ag;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_d, prod_q;
  logic [55:0]        mh_q;
  logic [63:0]        gsq_q;

  assign c1 = apu_pkg::OneQ24 - {1'b0, b1_q};
  assign c2 = apu_pkg::OneQ24 - {1'b0, b2_q};
  assign ag = g_q[31] ? 32'(-g_q) : 32'(g_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_op)
      apu_pkg::MUL_P1:  begin mul_a = {8'b0, p1_q};             mul_b = {9'b0, b1_q};   end
      apu_pkg::MUL_P2:  begin mul_a = {8'b0, p2_q};             mul_b = {9'b0, b2_q};   end
      apu_pkg::MUL_M1:  begin mul_a = {m_old[31], m_old};       mul_b = {9'b0, b1_q};   end
      apu_pkg::MUL_M2:  begin mul_a = {8'b0, c1};               mul_b = {g_q[31], g_q}; end
      apu_pkg::MUL_GSQ: begin mul_a = {1'b0, ag};               mul_b = {1'b0, ag};     end
      apu_pkg::MUL_V1:  begin mul_a = {1'b0, v_old[31:0]};      mul_b = {9'b0, b2_q};   end
      apu_pkg::MUL_V2:  begin mul_a = {1'b0, v_old[63:32]};     mul_b = {9'b0, b2_q};   end
      apu_pkg::MUL_V3:  begin mul_a = {1'b0, gsq_q[31:0]};      mul_b = {8'b0, c2};     end
      apu_pkg::MUL_V4:  begin mul_a = {1'b0, gsq_q[63:32]};     mul_b = {8'b0, c2};     end
      apu_pkg::MUL_N1:  begin mul_a = {1'b0, mh_q[23:0], 8'b0}; mul_b = {9'b0, rate_q}; end
      apu_pkg::MUL_N2:  begin mul_a = {1'b0, mh_q[55:24]};      mul_b = {9'b0, rate_q}; end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // accumulate the registered product
  logic signed [AccW-1:0] acc_q, prod_x, prod_sh, acc_plus, acc_plus_sh;
  logic signed [AccW-1:0] psum, msum, vsum;
  logic signed [31:0]     m_q, m_new;
  logic [63:0]            v_q, v_new;
  logic [87:0]            n_q;

  assign prod_x      = {{(AccW-66){prod_q[65]}}, prod_q};
  assign prod_sh     = {prod_x[AccW-33:0], 32'b0};
  assign acc_plus    = acc_q + prod_x;
  assign acc_plus_sh = acc_q + prod_sh;
  assign psum        = prod_x + Half;
  assign msum        = acc_plus + Half;
  assign vsum        = acc_plus_sh + Half;
  assign m_new       = msum[55:24];
  assign v_new       = vsum[87:24];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_q <= apu_pkg::MUL_NONE;
      p1_q  <= apu_pkg::OneQ24;
      p2_q  <= apu_pkg::OneQ24;
      vld_q <= '0;
    end else begin
      pop_q <= cmd_i.mul_op;
      case (pop_q)
        apu_pkg::MUL_P1: p1_q <= psum[48:24];
        apu_pkg::MUL_P2: p2_q <= psum[48:24];
        apu_pkg::MUL_V4: vld_q[addr] <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (pop_q)
      apu_pkg::MUL_M1:  acc_q <= prod_x;
      apu_pkg::MUL_M2:  begin
        m_q         <= m_new;
        m_mem[addr] <= m_new;
      end
      apu_pkg::MUL_GSQ: gsq_q <= prod_q[63:0];
      apu_pkg::MUL_V1:  acc_q <= prod_x;
      apu_pkg::MUL_V2:  acc_q <= acc_plus_sh;
      apu_pkg::MUL_V3:  acc_q <= acc_plus;
      apu_pkg::MUL_V4:  begin
        v_q         <= v_new;
        v_mem[addr] <= v_new;
      end
      apu_pkg::MUL_N1:  acc_q <= prod_x;
      apu_pkg::MUL_N2:  n_q <= acc_plus_sh[87:0];
      default: ;
    endcase
  end

  // divide / square root operands
  logic [24:0]                 d1_raw, d2_raw, d1, d2;
  logic [48:0]                 dv_raw, dv;
  logic [31:0]                 am, root_q;
  logic [63:0]                 vh;
  logic [apu_pkg::NumW-1:0]    dsu_num, dsu_quo;
  logic [apu_pkg::DenW-1:0]    dsu_den;
  logic [apu_pkg::CntW-1:0]    dsu_cnt;
  logic                        dsu_sqrt, dsu_done;
  apu_pkg::dsu_op_e            run_op_q;
  logic [34:0]                 q_q;

  assign d1_raw = apu_pkg::OneQ24 - p1_q;
  assign d2_raw = apu_pkg::OneQ24 - p2_q;
  assign d1     = (d1_raw == '0) ? 25'd1 : d1_raw;
  assign d2     = (d2_raw == '0) ? 25'd1 : d2_raw;
  assign dv_raw = {1'b0, root_q, 16'b0} + {17'b0, eps_q};
  assign dv     = (dv_raw == '0) ? 49'd1 : dv_raw;
  assign am     = m_q[31] ? 32'(-m_q) : 32'(m_q);
  assign vh     = (|dsu_quo[87:64]) ? '1 : dsu_quo[63:0];

  always_comb begin
    dsu_num  = '0;
    dsu_den  = '0;
    dsu_cnt  = apu_pkg::DivQSteps;
    dsu_sqrt = 1'b0;
    case (cmd_i.dsu_op)
      apu_pkg::DSU_DIV_M: begin
        dsu_num = {am, 56'b0};
        dsu_den = {24'b0, d1};
        dsu_cnt = apu_pkg::DivMSteps;
      end
      apu_pkg::DSU_DIV_V: begin
        dsu_num = {v_q, 24'b0};
        dsu_den = {24'b0, d2};
        dsu_cnt = apu_pkg::DivVSteps;
      end
      apu_pkg::DSU_SQRT: begin
        dsu_num  = {vh, 24'b0};
        dsu_cnt  = apu_pkg::SqrtSteps;
        dsu_sqrt = 1'b1;
      end
      apu_pkg::DSU_DIV_Q: begin
        dsu_num = n_q;
        dsu_den = dv;
        dsu_cnt = apu_pkg::DivQSteps;
      end
      default: ;
    endcase
  end

  apu_dsu u_dsu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.dsu_start),
    .sqrt_i  (dsu_sqrt),
    .num_i   (dsu_num),
    .den_i   (dsu_den),
    .count_i (dsu_cnt),
    .done_o  (dsu_done),
    .quo_o   (dsu_quo)
  );

  // keep the results of finished jobs
  always_ff @(posedge clk_i) begin
    if (cmd_i.dsu_start) begin
      run_op_q <= cmd_i.dsu_op;
    end
    if (dsu_done) begin
      case (run_op_q)
        apu_pkg::DSU_DIV_M: mh_q   <= dsu_quo[55:0];
        apu_pkg::DSU_SQRT:  root_q <= dsu_quo[31:0];
        apu_pkg::DSU_DIV_Q: q_q    <= (|dsu_quo[87:34]) ? 35'h4_0000_0000 : {1'b0, dsu_quo[33:0]};
        default: ;
      endcase
    end
  end

  // apply the step and clamp
  logic signed [35:0] p_x, q_x, r;
  logic signed [31:0] upd_q;
  logic               sat_q;

  assign p_x = {{4{p_q[31]}}, p_q};
  assign q_x = {1'b0, q_q};
  assign r   = m_q[31] ? (p_x + q_x) : (p_x - q_x);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (oor_q) begin
        upd_q <= p_q;
        sat_q <= 1'b0;
      end else if (r > MaxQ) begin
        upd_q <= 32'sh7fffffff;
        sat_q <= 1'b1;
      end else if (r < MinQ) begin
        upd_q <= 32'sh80000000;
        sat_q <= 1'b1;
      end else begin
        upd_q <= r[31:0];
        sat_q <= 1'b0;
      end
    end
  end

  assign updated_param_o = upd_q;
  assign saturated_o     = sat_q;

  // status toward the controller
  assign stat_o.idx_zero = (element_index_i == '0);
  assign stat_o.idx_out  = (idx_in_ext >= 9'(VECTOR_LENGTH));
  assign stat_o.mul_busy = (pop_q != apu_pkg::MUL_NONE);
  assign stat_o.dsu_done = dsu_done;

endmodule

`default_nettype wire

[design/apu_ctrl.sv]
`default_nettype none

module apu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  apu_pkg::apu_stat_t stat_i,
  output apu_pkg::apu_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL_A = 3'd1;
  localparam logic [2:0] ST_DIV_M = 3'd2;
  localparam logic [2:0] ST_DIV_V = 3'd3;
  localparam logic [2:0] ST_SQRT  = 3'd4;
  localparam logic [2:0] ST_MUL_N = 3'd5;
  localparam logic [2:0] ST_DIV_Q = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]        state_q, state_d;
  apu_pkg::mul_op_e  op_q, op_d, op_next;
  logic              out_valid_q, out_valid_d;

  // multiply sequence order
  always_comb begin
    case (op_q)
      apu_pkg::MUL_P1:  op_next = apu_pkg::MUL_P2;
      apu_pkg::MUL_P2:  op_next = apu_pkg::MUL_M1;
      apu_pkg::MUL_M1:  op_next = apu_pkg::MUL_M2;
      apu_pkg::MUL_M2:  op_next = apu_pkg::MUL_GSQ;
      apu_pkg::MUL_GSQ: op_next = apu_pkg::MUL_V1;
      apu_pkg::MUL_V1:  op_next = apu_pkg::MUL_V2;
      apu_pkg::MUL_V2:  op_next = apu_pkg::MUL_V3;
      apu_pkg::MUL_V3:  op_next = apu_pkg::MUL_V4;
      apu_pkg::MUL_N1:  op_next = apu_pkg::MUL_N2;
      default:          op_next = apu_pkg::MUL_NONE;
    endcase
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cmd_o        = '0;
    cmd_o.mul_op = apu_pkg::MUL_NONE;
    cmd_o.dsu_op = apu_pkg::DSU_DIV_M;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.idx_out) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_MUL_A;
            op_d    = stat_i.idx_zero ? apu_pkg::MUL_P1 : apu_pkg::MUL_M1;
          end
        end
      end
      ST_MUL_A: begin
        cmd_o.mul_op = op_q;
        if (op_q != apu_pkg::MUL_NONE) begin
          op_d = op_next;
        end else if (!stat_i.mul_busy) begin
          cmd_o.dsu_start = 1'b1;
          cmd_o.dsu_op    = apu_pkg::DSU_DIV_M;
          state_d         = ST_DIV_M;
        end
      end
      ST_DIV_M: begin
        if (stat_i.dsu_done) begin
          cmd_o.dsu_start = 1'b1;
          cmd_o.dsu_op    = apu_pkg::DSU_DIV_V;
          state_d         = ST_DIV_V;
        end
      end
      ST_DIV_V: begin
        if (stat_i.dsu_done) begin
          cmd_o.dsu_start = 1'b1;
          cmd_o.dsu_op    = apu_pkg::DSU_SQRT;
          state_d         = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (stat_i.dsu_done) begin
          op_d    = apu_pkg::MUL_N1;
          state_d = ST_MUL_N;
        end
      end
      ST_MUL_N: begin
        cmd_o.mul_op = op_q;
        if (op_q != apu_pkg::MUL_NONE) begin
          op_d = op_next;
        end else if (!stat_i.mul_busy) begin
          cmd_o.dsu_start = 1'b1;
          cmd_o.dsu_op    = apu_pkg::DSU_DIV_Q;
          state_d         = ST_DIV_Q;
        end
      end
      ST_DIV_Q: begin
        if (stat_i.dsu_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= apu_pkg::MUL_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[design/adam_parameter_update_unit.sv]
// an item with an index in range runs the multiply sequence and the four divide / square
//   root jobs in turn on the shared one-bit-per-cycle unit (56 + 88 + 32 + 88 steps); an
//   item out of range passes its parameter through; the next item is taken only after
//   the last one is through, while its result may still wait in the output register
// reset: asynchronous, active low; moments read as zero, decay powers one, registers
//   at their defaults; no clearing pass
`default_nettype none

module adam_parameter_update_unit #(
  parameter int unsigned VECTOR_LENGTH = apu_pkg::VectorLengthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [apu_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [apu_pkg::IdxW-1:0]    element_index_i,
  input  logic signed [31:0]          grad_value_i,
  input  logic signed [31:0]          param_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [31:0]          updated_param_o,
  output logic                        saturated_o
);

  apu_pkg::apu_cmd_t  cmd;
  apu_pkg::apu_stat_t stat;

  // configuration is taken in any cycle
  assign cfg_ready_o = 1'b1;

  apu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  apu_dp #(
    .VECTOR_LENGTH (VECTOR_LENGTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .element_index_i (element_index_i),
    .grad_value_i    (grad_value_i),
    .param_value_i   (param_value_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .updated_param_o (updated_param_o),
    .saturated_o     (saturated_o)
  );

endmodule

`default_nettype wire
